[hdl/assert_macros.svh]
// Assertion helpers used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[hdl/sfps_pkg.sv]
package sfps_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam logic [8:0] MAX_CHUNK     = 9'd256;
	localparam logic [4:0] PAGE_LOG2_MAX = 5'd16;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 9;

	localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_SHIFT       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHUNK_SIZE       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_NATIVE_4BA_WRITE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHIP_4BA_MODE    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_MASTER_4BA       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_EAR_KIND         = 3'd5;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_NEXT = 1'b1;

	localparam logic [1:0] ERR_OK          = 2'd0;
	localparam logic [1:0] ERR_NO_4BA      = 2'd1;
	localparam logic [1:0] ERR_UNREACHABLE = 2'd2;

	localparam logic [1:0] EAR_NONE = 2'd0;

	localparam logic [2:0] ADDR_BYTES_3 = 3'd3;
	localparam logic [2:0] ADDR_BYTES_4 = 3'd4;

	typedef struct packed {
		logic        action;
		logic [31:0] base_addr;
		logic [31:0] length;
	} item_t;

	typedef struct packed {
		logic        cmd_valid;
		logic        opcode_is_4ba;
		logic [31:0] cmd_address;
		logic [2:0]  address_bytes;
		logic [8:0]  byte_count;
		logic [31:0] data_offset;
		logic        ear_write;
		logic [7:0]  ear_value;
		logic [1:0]  error;
		logic        done_res;
	} result_t;

	typedef struct packed {
		logic [4:0] page_shift;
		logic [8:0] chunk_size;
		logic       native_4ba_write;
		logic       chip_4ba_mode;
		logic       master_4ba;
		logic [1:0] ear_kind;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		page_shift:       5'd8,
		chunk_size:       9'd256,
		native_4ba_write: 1'b0,
		chip_4ba_mode:    1'b0,
		master_4ba:       1'b0,
		ear_kind:         EAR_NONE
	};

	// Classified word handed from the front to the back.
	typedef struct packed {
		logic        is_load;
		logic        len_zero;
		logic [31:0] base_addr;
		logic [31:0] length;
	} entry_t;

endpackage

[hdl/sfps_front.sv]
module sfps_front
	import sfps_pkg::*;
(
	input  logic   item_valid,
	output logic   item_ready,
	input  item_t  item,
	input  logic   full,
	output logic   push,
	output entry_t entry
);

	assign item_ready = !full;
	assign push       = item_valid && !full;

	always_comb begin
		entry.is_load   = (item.action == ACT_LOAD);
		entry.len_zero  = (item.length == 32'd0);
		entry.base_addr = item.base_addr;
		entry.length    = item.length;
	end

endmodule

[hdl/sfps_queue.sv]
module sfps_queue
	import sfps_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	output logic   full,
	input  logic   pop,
	output entry_t rd_entry,
	output logic   empty
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/sfps_back.sv]
module sfps_back
	import sfps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    empty,
	input  entry_t  rd_entry,
	output logic    pop,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic [31:0] next_address_q;
	logic [31:0] remaining_q;
	logic [31:0] consumed_q;
	logic [7:0]  shadow_q;
	logic        active_q;
	logic        result_valid_q;
	result_t     result_q;

	logic [4:0]  lg;
	logic [16:0] page_span;
	logic [16:0] page_left;
	logic [8:0]  chunk;
	logic [8:0]  lim;
	logic [8:0]  count;
	logic [7:0]  high;
	logic        native;
	logic        four;
	logic        ear_present;
	logic [1:0]  err;
	logic        last;
	result_t     res_d;

	assign pop          = !empty && (!result_valid_q || result_ready);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		lg        = (cfg.page_shift > PAGE_LOG2_MAX) ? PAGE_LOG2_MAX : cfg.page_shift;
		page_span = 17'd1 << lg;
		page_left = page_span - (next_address_q[16:0] & (page_span - 17'd1));

		priority if (cfg.chunk_size == 9'd0) begin
			chunk = 9'd1;
		end else if (cfg.chunk_size > MAX_CHUNK) begin
			chunk = MAX_CHUNK;
		end else begin
			chunk = cfg.chunk_size;
		end

		lim   = (page_left < {8'd0, chunk}) ? page_left[8:0] : chunk;
		count = (remaining_q < {23'd0, lim}) ? remaining_q[8:0] : lim;
		last  = (remaining_q == {23'd0, count});

		high        = next_address_q[31:24];
		native      = cfg.native_4ba_write && cfg.master_4ba;
		four        = native || cfg.chip_4ba_mode;
		ear_present = (cfg.ear_kind != EAR_NONE);

		priority if (four && !cfg.master_4ba) begin
			err = ERR_NO_4BA;
		end else if (!four && !ear_present && high != 8'd0) begin
			err = ERR_UNREACHABLE;
		end else begin
			err = ERR_OK;
		end

		res_d = '0;
		priority if (rd_entry.is_load) begin
			res_d.done_res = rd_entry.len_zero;
		end else if (active_q) begin
			res_d.cmd_address = next_address_q;
			res_d.data_offset = consumed_q;
			res_d.error       = err;
			if (err == ERR_OK) begin
				res_d.cmd_valid     = 1'b1;
				res_d.opcode_is_4ba = native;
				res_d.address_bytes = four ? ADDR_BYTES_4 : ADDR_BYTES_3;
				res_d.byte_count    = count;
				res_d.ear_write     = !four && ear_present && (high != shadow_q);
				res_d.ear_value     = res_d.ear_write ? high : 8'd0;
				res_d.done_res      = last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			next_address_q <= '0;
			remaining_q    <= '0;
			consumed_q     <= '0;
			shadow_q       <= '0;
			active_q       <= 1'b0;
		end else begin
			if (pop) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			if (pop) begin
				priority if (rd_entry.is_load) begin
					next_address_q <= rd_entry.base_addr;
					remaining_q    <= rd_entry.length;
					consumed_q     <= '0;
					active_q       <= !rd_entry.len_zero;
				end else if (active_q) begin
					if (err != ERR_OK) begin
						active_q <= 1'b0;
					end else begin
						next_address_q <= next_address_q + {23'd0, count};
						remaining_q    <= remaining_q - {23'd0, count};
						consumed_q     <= consumed_q + {23'd0, count};
						if (!four && ear_present) begin
							shadow_q <= high;
						end
						if (last) begin
							active_q <= 1'b0;
						end
					end
				end
			end
		end
	end

endmodule

[hdl/spi_flash_program_splitter_unit.sv]
// SPI NOR page-program splitter. A load word stores a write request (start address,
// length); each following next word, while the request is active and error-free,
// returns one page-program command that stays inside one page and within the chunk
// size, with its address, byte count, source offset, address form and any
// extended-address register write. Every input word gives exactly one result word.
// Input words pass through a short queue (QUEUE_DEPTH entries) to an execution stage
// that updates the request state and registers the result; it sustains one word per
// clock while results are taken, and the queue absorbs up to QUEUE_DEPTH words while
// the result side stalls. Configuration writes take effect at the next clock edge;
// the user must make them only while no request word is in flight (not enforced).
module spi_flash_program_splitter_unit
	import sfps_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  item_t                  item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output result_t                result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t   cfg_q;
	logic   full;
	logic   empty;
	logic   push;
	logic   pop;
	entry_t wr_entry;
	entry_t rd_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAGE_SHIFT:       cfg_q.page_shift       <= cfg_data[4:0];
				CFG_CHUNK_SIZE:       cfg_q.chunk_size       <= cfg_data[8:0];
				CFG_NATIVE_4BA_WRITE: cfg_q.native_4ba_write <= cfg_data[0];
				CFG_CHIP_4BA_MODE:    cfg_q.chip_4ba_mode    <= cfg_data[0];
				CFG_MASTER_4BA:       cfg_q.master_4ba       <= cfg_data[0];
				CFG_EAR_KIND:         cfg_q.ear_kind         <= cfg_data[1:0];
				default:              cfg_q                  <= cfg_q;
			endcase
		end
	end

	sfps_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.full       (full),
		.push       (push),
		.entry      (wr_entry)
	);

	sfps_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (full),
		.pop      (pop),
		.rd_entry (rd_entry),
		.empty    (empty)
	);

	sfps_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.empty        (empty),
		.rd_entry     (rd_entry),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

[hdl/sfps_port_checker.sv]
`include "assert_macros.svh"

module sfps_port_checker
	import sfps_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))
	`ASSERT_NOW(a_error_no_cmd, clk, arst_n, result_valid && result.error != ERR_OK, !result.cmd_valid && !result.done_res)
	`ASSERT_NOW(a_count_range, clk, arst_n, result_valid && result.cmd_valid, result.byte_count != 9'd0 && result.byte_count <= MAX_CHUNK)
	`ASSERT_NOW(a_ear_3byte, clk, arst_n, result_valid && result.ear_write, result.cmd_valid && result.address_bytes == ADDR_BYTES_3)

endmodule

bind spi_flash_program_splitter_unit sfps_port_checker u_port_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

[tb/spi_flash_program_splitter_scoreboard.sv]
module spi_flash_program_splitter_scoreboard
	import sfps_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_ready,
	input  item_t                  item,
	input  logic                   result_valid,
	input  logic                   result_ready,
	input  result_t                result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     pending,
	output int                     commands,
	output int                     errors,
	output int                     completions
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t        regs = CFG_RESET;
	logic [31:0] next_addr = '0;
	logic [31:0] bytes_left = '0;
	logic [31:0] bytes_done = '0;
	logic [7:0]  high_shadow = '0;
	logic        busy = 1'b0;
	result_t     expected_cmds[$];
	int          results_seen = 0;

	function automatic result_t plan_command(input item_t w);
		result_t     r;
		logic [31:0] addr;
		logic [31:0] span;
		logic [31:0] page_left;
		logic [31:0] count;
		logic [4:0]  lg;
		logic [8:0]  chunk;
		logic [7:0]  high;
		logic        native;
		logic        four;
		r = '0;
		if (w.action == ACT_LOAD) begin
			next_addr = w.base_addr;
			bytes_left = w.length;
			bytes_done = '0;
			busy = (w.length != 0);
			r.done_res = (w.length == 0);
			return r;
		end
		if (!busy)
			return r;
		addr = next_addr;
		high = addr[31:24];
		native = regs.native_4ba_write & regs.master_4ba;
		four = native | regs.chip_4ba_mode;
		r.cmd_address = addr;
		r.data_offset = bytes_done;
		if (four && !regs.master_4ba) begin
			r.error = ERR_NO_4BA;
			busy = 1'b0;
			return r;
		end
		if (!four) begin
			if (regs.ear_kind != EAR_NONE) begin
				if (high != high_shadow) begin
					r.ear_write = 1'b1;
					r.ear_value = high;
				end
				high_shadow = high;
			end else if (high != 8'd0) begin
				r.error = ERR_UNREACHABLE;
				busy = 1'b0;
				return r;
			end
		end
		lg = (regs.page_shift > PAGE_LOG2_MAX) ? PAGE_LOG2_MAX : regs.page_shift;
		span = 32'd1 << lg;
		page_left = span - (addr & (span - 32'd1));
		if (regs.chunk_size == 9'd0)
			chunk = 9'd1;
		else if (regs.chunk_size > MAX_CHUNK)
			chunk = MAX_CHUNK;
		else
			chunk = regs.chunk_size;
		count = bytes_left;
		if (count > page_left)
			count = page_left;
		if (count > {23'd0, chunk})
			count = {23'd0, chunk};
		r.cmd_valid = 1'b1;
		r.opcode_is_4ba = native;
		r.address_bytes = four ? ADDR_BYTES_4 : ADDR_BYTES_3;
		r.byte_count = count[8:0];
		r.error = ERR_OK;
		next_addr = addr + count;
		bytes_left = bytes_left - count;
		bytes_done = bytes_done + count;
		if (bytes_left == 0) begin
			busy = 1'b0;
			r.done_res = 1'b1;
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		if (fail_count < 40)
			$display("[%0t] result word %0d: %s", $realtime, results_seen, msg);
		fail_count++;
	endtask

	task automatic compare_result(input result_t got, input result_t want);
		if (got.cmd_valid !== want.cmd_valid)
			flag_mismatch($sformatf("cmd_valid %0b, expected %0b", got.cmd_valid, want.cmd_valid));
		if (got.opcode_is_4ba !== want.opcode_is_4ba)
			flag_mismatch($sformatf("opcode_is_4ba %0b, expected %0b",
				got.opcode_is_4ba, want.opcode_is_4ba));
		if (got.cmd_address !== want.cmd_address)
			flag_mismatch($sformatf("cmd_address %h, expected %h",
				got.cmd_address, want.cmd_address));
		if (got.address_bytes !== want.address_bytes)
			flag_mismatch($sformatf("address_bytes %0d, expected %0d",
				got.address_bytes, want.address_bytes));
		if (got.byte_count !== want.byte_count)
			flag_mismatch($sformatf("byte_count %0d, expected %0d",
				got.byte_count, want.byte_count));
		if (got.data_offset !== want.data_offset)
			flag_mismatch($sformatf("data_offset %h, expected %h",
				got.data_offset, want.data_offset));
		if (got.ear_write !== want.ear_write)
			flag_mismatch($sformatf("ear_write %0b, expected %0b", got.ear_write, want.ear_write));
		if (got.ear_value !== want.ear_value)
			flag_mismatch($sformatf("ear_value %h, expected %h", got.ear_value, want.ear_value));
		if (got.error !== want.error)
			flag_mismatch($sformatf("error %0d, expected %0d", got.error, want.error));
		if (got.done_res !== want.done_res)
			flag_mismatch($sformatf("done_res %0b, expected %0b", got.done_res, want.done_res));
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			regs = CFG_RESET;
			next_addr = '0;
			bytes_left = '0;
			bytes_done = '0;
			high_shadow = '0;
			busy = 1'b0;
			expected_cmds.delete();
			results_seen = 0;
			fail_count = 0;
			commands = 0;
			errors = 0;
			completions = 0;
			pending <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_cmds.size() == 0) begin
					flag_mismatch("result word with nothing outstanding");
				end else begin
					want = expected_cmds.pop_front();
					compare_result(result, want);
					commands += want.cmd_valid;
					errors += (want.error != ERR_OK);
					completions += want.done_res;
				end
				results_seen++;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_PAGE_SHIFT:       regs.page_shift = cfg_data[4:0];
					CFG_CHUNK_SIZE:       regs.chunk_size = cfg_data[8:0];
					CFG_NATIVE_4BA_WRITE: regs.native_4ba_write = cfg_data[0];
					CFG_CHIP_4BA_MODE:    regs.chip_4ba_mode = cfg_data[0];
					CFG_MASTER_4BA:       regs.master_4ba = cfg_data[0];
					CFG_EAR_KIND:         regs.ear_kind = cfg_data[1:0];
					default: ;
				endcase
			end
			if (item_valid && item_ready)
				expected_cmds.push_back(plan_command(item));
			pending <= expected_cmds.size();
		end
	end

endmodule

[tb/spi_flash_program_splitter_unit_test.sv]
module spi_flash_program_splitter_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sfps_pkg::*;

	localparam int CYCLE_LIMIT = 250000;
	localparam int WORD_TARGET = 950;
	localparam int N_PHASES    = 8;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_ready;
	item_t                  item = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	result_t                result;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int fail_count;
	int pending;
	int commands;
	int errors;
	int completions;

	bit idling = 1'b1;
	int ready_hold = 0;
	int cycles = 0;
	int words_sent = 0;
	int settings = 0;

	spi_flash_program_splitter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	spi_flash_program_splitter_scoreboard scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.commands     (commands),
		.errors       (errors),
		.completions  (completions)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
			$display("FAIL spi_flash_program_splitter_unit");
			$finish;
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			ready_hold <= 0;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
			result_ready <= (ready_hold == 1);
		end else if (idling && $urandom_range(0, 11) == 0) begin
			ready_hold <= $urandom_range(1, 15);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic send_word(input item_t w);
		if (idling && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (!item_ready);
		words_sent++;
	endtask

	task automatic load_request(input logic [31:0] addr, input logic [31:0] len);
		item_t w;
		w.action = ACT_LOAD;
		w.base_addr = addr;
		w.length = len;
		send_word(w);
	endtask

	// address and length are don't-care on a next word, so fill them with junk
	task automatic next_command();
		item_t w;
		w.action = ACT_NEXT;
		w.base_addr = $urandom();
		w.length = $urandom();
		send_word(w);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	// unused upper bits of the data bus carry junk
	task automatic apply_setting(input cfg_t c);
		write_reg(CFG_PAGE_SHIFT, {4'($urandom()), c.page_shift});
		write_reg(CFG_CHUNK_SIZE, c.chunk_size);
		write_reg(CFG_NATIVE_4BA_WRITE, {8'($urandom()), c.native_4ba_write});
		write_reg(CFG_CHIP_4BA_MODE, {8'($urandom()), c.chip_4ba_mode});
		write_reg(CFG_MASTER_4BA, {8'($urandom()), c.master_4ba});
		write_reg(CFG_EAR_KIND, {7'($urandom()), c.ear_kind});
		cfg_we <= 1'b0;
		settings++;
	endtask

	function automatic logic [31:0] pick_address();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return {8'h00, 24'($urandom())};
			2: return 32'h0100_0000 - $urandom_range(1, 600);
			3: return {8'($urandom()), 24'hFF_FFFF} - $urandom_range(0, 600);
			4: return 32'hFFFF_FFFF - $urandom_range(0, 600);
			default: return {8'($urandom_range(0, 3)), 24'($urandom())};
		endcase
	endfunction

	function automatic logic [31:0] pick_length();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return $urandom();
			2, 3: return $urandom_range(257, 1200);
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	function automatic cfg_t pick_setting(input int phase);
		cfg_t c;
		case (phase)
			0: c = '{page_shift: 5'd0, chunk_size: 9'd1, native_4ba_write: 1'b0,
				chip_4ba_mode: 1'b0, master_4ba: 1'b0, ear_kind: 2'd1};
			1: c = '{page_shift: 5'd16, chunk_size: 9'd256, native_4ba_write: 1'b1,
				chip_4ba_mode: 1'b0, master_4ba: 1'b1, ear_kind: EAR_NONE};
			2: c = '{page_shift: 5'd31, chunk_size: 9'd511, native_4ba_write: 1'b0,
				chip_4ba_mode: 1'b1, master_4ba: 1'b1, ear_kind: 2'd2};
			3: c = '{page_shift: 5'd8, chunk_size: 9'd0, native_4ba_write: 1'b0,
				chip_4ba_mode: 1'b0, master_4ba: 1'b0, ear_kind: EAR_NONE};
			default: begin
				c.page_shift = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
					: 5'($urandom_range(2, 9));
				c.chunk_size = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 511))
					: 9'($urandom_range(1, 64));
				c.native_4ba_write = 1'($urandom());
				c.chip_4ba_mode = ($urandom_range(0, 2) == 0);
				c.master_4ba = 1'($urandom());
				c.ear_kind = 2'($urandom_range(0, 3));
			end
		endcase
		return c;
	endfunction

	initial begin
		item_t w;
		int    phase_end;
		int    n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: 3-byte addressing, no extended register
		next_command();
		load_request(32'h00FF_FFF0, 32'd0);
		load_request(32'h00FF_FFF0, 32'h40);
		next_command();
		next_command();
		next_command();
		load_request(32'h0000_00FF, 32'd2);
		next_command();
		next_command();
		load_request(32'h0000_0000, 32'hFFFF_FFFF);
		next_command();
		load_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		next_command();
		drain();

		// native 4-byte across the top of the address space
		apply_setting('{page_shift: 5'd16, chunk_size: 9'd511, native_4ba_write: 1'b1,
			chip_4ba_mode: 1'b0, master_4ba: 1'b1, ear_kind: EAR_NONE});
		load_request(32'hFFFF_FF80, 32'h200);
		repeat (3) next_command();
		drain();

		// 4-byte mode with a 3-byte-only controller
		apply_setting('{page_shift: 5'd0, chunk_size: 9'd0, native_4ba_write: 1'b0,
			chip_4ba_mode: 1'b1, master_4ba: 1'b0, ear_kind: 2'd3});
		load_request(32'h01FF_FFFF, 32'd3);
		next_command();
		drain();

		// extended register, saturated page size, chunk of one
		apply_setting('{page_shift: 5'd31, chunk_size: 9'd0, native_4ba_write: 1'b0,
			chip_4ba_mode: 1'b0, master_4ba: 1'b0, ear_kind: 2'd3});
		load_request(32'h01FF_FFFF, 32'd3);
		repeat (3) next_command();
		load_request(32'h0000_0010, 32'd1);
		next_command();
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			apply_setting(pick_setting(p));
			if (p == N_PHASES - 1)
				idling <= 1'b0;
			phase_end = words_sent + (WORD_TARGET / N_PHASES);
			while (words_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					w.action = 1'($urandom());
					w.base_addr = $urandom();
					w.length = $urandom();
					send_word(w);
				end else begin
					load_request(pick_address(), pick_length());
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
						: $urandom_range(1, 10);
					repeat (n) next_command();
				end
			end
			drain();
		end

		$display("%0d words over %0d register settings", words_sent, settings);
		$display("%0d commands, %0d errors, %0d requests completed",
			commands, errors, completions);
		if (fail_count == 0 && pending == 0)
			$display("PASS spi_flash_program_splitter_unit");
		else
			$display("FAIL spi_flash_program_splitter_unit");
		$finish;
	end

endmodule
